// ===== rtl/traffic_class_counters_core_assert.svh =====
// Assertion macros for the traffic class counter core.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef TRAFFIC_CLASS_COUNTERS_CORE_ASSERT_SVH
`define TRAFFIC_CLASS_COUNTERS_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define TCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/tcc_pkg.sv =====
// Shared types, codes and helpers for the traffic class counter core.
// Depends on nothing; every source file but tcc_ram and the assertion header imports it.
package tcc_pkg;

   localparam int ETHER_SLOTS_DEF = 16;
   localparam int PORT_RANGES_DEF = 4;
   localparam int WIFI_KINDS      = 64;
   localparam int RANGE_REGS      = 4;
   localparam int MAX_RANGES      = 16;
   localparam int CNT_W           = 64;

   // Command codes.
   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Class codes, also bit positions in the enable and present masks.
   localparam logic [2:0] CLS_ETHER = 3'd0;
   localparam logic [2:0] CLS_WIFI  = 3'd1;
   localparam logic [2:0] CLS_IP    = 3'd2;
   localparam logic [2:0] CLS_TCP   = 3'd3;
   localparam logic [2:0] CLS_UDP   = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ENABLE     = 3'd0;
   localparam logic [2:0] CSR_TCP_COUNT  = 3'd1;
   localparam logic [2:0] CSR_UDP_COUNT  = 3'd2;
   localparam logic [2:0] CSR_TCP_FIRST  = 3'd3;
   localparam logic [2:0] CSR_TCP_SECOND = 3'd4;
   localparam logic [2:0] CSR_UDP_FIRST  = 3'd5;
   localparam logic [2:0] CSR_UDP_SECOND = 3'd6;

   typedef struct packed {
      logic        cmd;
      logic [15:0] frame_length;
      logic [4:0]  present_mask;
      logic [15:0] ether_type;
      logic [5:0]  wifi_kind;
      logic [7:0]  ip_protocol;
      logic [15:0] ip_total_length;
      logic [3:0]  ip_header_words;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [2:0]  read_class;
      logic [7:0]  read_index;
   } tcc_req_type;

   typedef struct packed {
      logic [2:0]  record_class;
      logic [15:0] key_type;
      logic [15:0] key_subtype;
      logic [63:0] packet_total;
      logic [63:0] byte_total;
      logic        entry_used;
      logic        ether_overflow;
   } tcc_rsp_type;

   // Classified work item handed from the front end to the back end.
   typedef struct packed {
      logic                  cmd;
      logic [4:0]            act;
      logic [15:0]           frame_length;
      logic [15:0]           ip_total_length;
      logic [15:0]           l4_length;
      logic [15:0]           ether_type;
      logic [5:0]            wifi_kind;
      logic [7:0]            ip_protocol;
      logic [MAX_RANGES-1:0] tcp_hit;
      logic [MAX_RANGES-1:0] udp_hit;
      logic [2:0]            read_class;
      logic [7:0]            read_index;
   } tcc_op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } tcc_qstat_type;

   typedef struct packed {
      logic [4:0]  enable;
      logic [2:0]  tcp_count;
      logic [2:0]  udp_count;
      logic [63:0] tcp_first;
      logic [63:0] tcp_second;
      logic [63:0] udp_first;
      logic [63:0] udp_second;
   } tcc_cfg_type;

   // Low or high port of a range; ranges without a register read as zero.
   function automatic logic [15:0] range_port(input logic [63:0] first,
                                              input logic [63:0] second,
                                              input logic [7:0]  r,
                                              input logic        hi);
      logic [63:0] word;
      logic [5:0]  sh;
      word = r[1] ? second : first;
      sh   = {r[0], hi, 4'b0000};
      if (r > 8'(RANGE_REGS - 1)) begin
         return 16'd0;
      end
      return word[sh +: 16];
   endfunction

endpackage

// ===== rtl/tcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tcc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== rtl/tcc_queue.sv =====
// Two-entry queue of classified work items between front and back end.
// Depends on tcc_pkg.
module tcc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tcc_pkg::tcc_op_type    push_op,
   input  logic                   pop,
   output tcc_pkg::tcc_op_type    head_op,
   output tcc_pkg::tcc_qstat_type stat
);
   import tcc_pkg::*;

   tcc_op_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_op;
      end
   end

   assign head_op    = slot_ff[rd_ff];
   assign stat.empty = (count_ff == 2'd0);
   assign stat.full  = (count_ff == 2'd2);

endmodule

// ===== rtl/tcc_front.sv =====
// Front end: classifies one request into a work item for the back end.
// Depends on tcc_pkg.
module tcc_front #(
   parameter int PORT_RANGES = tcc_pkg::PORT_RANGES_DEF
) (
   input  tcc_pkg::tcc_req_type req,
   input  tcc_pkg::tcc_cfg_type cfg,
   output tcc_pkg::tcc_op_type  op,
   output logic                 keep
);
   import tcc_pkg::*;

   logic [5:0]  hdr_bytes;
   logic [15:0] tlo, thi, ulo, uhi;

   always_comb begin
      op                 = '0;
      op.cmd             = req.cmd;
      op.frame_length    = req.frame_length;
      op.ip_total_length = req.ip_total_length;
      op.ether_type      = req.ether_type;
      op.wifi_kind       = req.wifi_kind;
      op.ip_protocol     = req.ip_protocol;
      op.read_class      = req.read_class;
      op.read_index      = req.read_index;

      // Classes that count: present, enabled, and IP for layer 4.
      op.act = req.present_mask & cfg.enable;
      op.act[CLS_TCP] = op.act[CLS_TCP] & req.present_mask[CLS_IP];
      op.act[CLS_UDP] = op.act[CLS_UDP] & req.present_mask[CLS_IP];

      // Layer-4 payload length, saturating at zero.
      hdr_bytes = {req.ip_header_words, 2'b00};
      op.l4_length = (req.ip_total_length >= 16'(hdr_bytes)) ?
                     req.ip_total_length - 16'(hdr_bytes) : 16'd0;

      // Port range matching on either port.
      for (int r = 0; r < MAX_RANGES; r++) begin
         tlo = range_port(cfg.tcp_first, cfg.tcp_second, 8'(r), 1'b0);
         thi = range_port(cfg.tcp_first, cfg.tcp_second, 8'(r), 1'b1);
         ulo = range_port(cfg.udp_first, cfg.udp_second, 8'(r), 1'b0);
         uhi = range_port(cfg.udp_first, cfg.udp_second, 8'(r), 1'b1);
         op.tcp_hit[r] = (r < PORT_RANGES) && (r < RANGE_REGS) && (r < int'(cfg.tcp_count))
            && ((req.source_port >= tlo && req.source_port <= thi)
             || (req.dest_port >= tlo && req.dest_port <= thi));
         op.udp_hit[r] = (r < PORT_RANGES) && (r < RANGE_REGS) && (r < int'(cfg.udp_count))
            && ((req.source_port >= ulo && req.source_port <= uhi)
             || (req.dest_port >= ulo && req.dest_port <= uhi));
      end

      // Reads of a class that does not exist give no result.
      keep = !(req.cmd == CMD_READ && req.read_class > CLS_UDP);
   end

endmodule

// ===== rtl/tcc_back.sv =====
// Back end: read-modify-write of the counter tables and read-and-clear.
// Depends on tcc_pkg and tcc_ram.
module tcc_back #(
   parameter int ETHER_SLOTS = tcc_pkg::ETHER_SLOTS_DEF,
   parameter int PORT_RANGES = tcc_pkg::PORT_RANGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tcc_pkg::tcc_cfg_type   cfg,
   input  tcc_pkg::tcc_op_type    head_op,
   input  tcc_pkg::tcc_qstat_type qstat,
   output logic                   pop,
   output logic                   rsp_strobe,
   output tcc_pkg::tcc_rsp_type   rsp_data,
   output logic                   overflow
);
   import tcc_pkg::*;

   localparam int ESW = (ETHER_SLOTS > 1) ? $clog2(ETHER_SLOTS) : 1;
   localparam int RW  = (PORT_RANGES > 1) ? $clog2(PORT_RANGES) : 1;
   localparam int PW  = 2 * CNT_W;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type   state_ff;
   tcc_op_type  op_ff;
   logic [15:0]      ekey_ff   [ETHER_SLOTS];
   logic [ETHER_SLOTS-1:0] evalid_ff;
   logic [CNT_W-1:0] epk_ff    [ETHER_SLOTS];
   logic [CNT_W-1:0] eby_ff    [ETHER_SLOTS];
   logic [WIFI_KINDS-1:0] wvalid_ff;
   logic [255:0]     pvalid_ff;
   logic [CNT_W-1:0] tpk_ff    [PORT_RANGES];
   logic [CNT_W-1:0] tby_ff    [PORT_RANGES];
   logic [CNT_W-1:0] upk_ff    [PORT_RANGES];
   logic [CNT_W-1:0] uby_ff    [PORT_RANGES];
   logic             overflow_ff;
   logic             rsp_valid_ff;
   tcc_rsp_type      rsp_ff, rsp_in;

   logic [5:0]  wifi_raddr, wifi_addr;
   logic [7:0]  proto_raddr, proto_addr;
   logic [PW-1:0] wifi_rdata, proto_rdata, wifi_wdata, proto_wdata;
   logic        wifi_we, proto_we;
   logic [CNT_W-1:0] wifi_pk, wifi_by, proto_pk, proto_by;

   logic [ESW-1:0] hit_idx, free_idx, e_idx;
   logic           hit_any, free_any, e_in_range;
   logic [CNT_W-1:0] e_pk, e_by;
   logic [RW-1:0]  r_idx;
   logic           r_in_range, wifi_in_range, is_exec, is_read;

   // Table reads are issued from the queue head while idle.
   always_comb begin
      wifi_raddr  = (head_op.cmd == CMD_READ) ? head_op.read_index[5:0] : head_op.wifi_kind;
      proto_raddr = (head_op.cmd == CMD_READ) ? head_op.read_index : head_op.ip_protocol;
      wifi_addr   = (op_ff.cmd == CMD_READ) ? op_ff.read_index[5:0] : op_ff.wifi_kind;
      proto_addr  = (op_ff.cmd == CMD_READ) ? op_ff.read_index : op_ff.ip_protocol;
   end

   tcc_ram #(.WIDTH(PW), .DEPTH(WIFI_KINDS)) u_wifi_ram (
      .clock(clock), .we(wifi_we), .waddr(wifi_addr), .wdata(wifi_wdata),
      .raddr(wifi_raddr), .rdata(wifi_rdata)
   );

   tcc_ram #(.WIDTH(PW), .DEPTH(256)) u_proto_ram (
      .clock(clock), .we(proto_we), .waddr(proto_addr), .wdata(proto_wdata),
      .raddr(proto_raddr), .rdata(proto_rdata)
   );

   // Entries never written since reset read as zero.
   always_comb begin
      wifi_pk  = wvalid_ff[wifi_addr] ? wifi_rdata[PW-1:CNT_W] : '0;
      wifi_by  = wvalid_ff[wifi_addr] ? wifi_rdata[CNT_W-1:0] : '0;
      proto_pk = pvalid_ff[proto_addr] ? proto_rdata[PW-1:CNT_W] : '0;
      proto_by = pvalid_ff[proto_addr] ? proto_rdata[CNT_W-1:0] : '0;
   end

   // Ethertype lookup: matching slot and lowest free slot.
   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = ETHER_SLOTS - 1; i >= 0; i--) begin
         if (evalid_ff[i] && ekey_ff[i] == op_ff.ether_type) begin
            hit_any = 1'b1;
            hit_idx = ESW'(i);
         end
         if (!evalid_ff[i]) begin
            free_any = 1'b1;
            free_idx = ESW'(i);
         end
      end
      e_in_range = ({1'b0, op_ff.read_index} < 9'(ETHER_SLOTS));
      if (op_ff.cmd == CMD_READ) begin
         e_idx = op_ff.read_index[ESW-1:0];
      end else begin
         e_idx = hit_any ? hit_idx : free_idx;
      end
      e_pk = epk_ff[e_idx];
      e_by = eby_ff[e_idx];
      r_in_range    = ({1'b0, op_ff.read_index} < 9'(PORT_RANGES));
      r_idx         = op_ff.read_index[RW-1:0];
      wifi_in_range = (op_ff.read_index[7:6] == 2'b00);
      is_exec       = (state_ff == S_EXEC);
      is_read       = (op_ff.cmd == CMD_READ);
   end

   // Table write-back for the direct tables.
   always_comb begin
      wifi_we     = 1'b0;
      proto_we    = 1'b0;
      wifi_wdata  = '0;
      proto_wdata = '0;
      if (is_exec) begin
         if (is_read) begin
            wifi_we  = (op_ff.read_class == CLS_WIFI) && wifi_in_range;
            proto_we = (op_ff.read_class == CLS_IP);
         end else begin
            wifi_we     = op_ff.act[CLS_WIFI];
            wifi_wdata  = {wifi_pk + 64'd1, wifi_by + 64'(op_ff.frame_length)};
            proto_we    = op_ff.act[CLS_IP];
            proto_wdata = {proto_pk + 64'd1, proto_by + 64'(op_ff.ip_total_length)};
         end
      end
   end

   // Read result for the addressed entry.
   always_comb begin
      rsp_in                = '0;
      rsp_in.record_class   = op_ff.read_class;
      rsp_in.ether_overflow = overflow_ff;
      case (op_ff.read_class)
         CLS_ETHER: begin
            if (e_in_range) begin
               rsp_in.key_type     = evalid_ff[e_idx] ? ekey_ff[e_idx] : 16'd0;
               rsp_in.entry_used   = evalid_ff[e_idx];
               rsp_in.packet_total = e_pk;
               rsp_in.byte_total   = e_by;
            end
         end
         CLS_WIFI: begin
            if (wifi_in_range) begin
               rsp_in.key_type     = {14'd0, op_ff.read_index[1:0]};
               rsp_in.key_subtype  = {12'd0, op_ff.read_index[5:2]};
               rsp_in.packet_total = wifi_pk;
               rsp_in.byte_total   = wifi_by;
               rsp_in.entry_used   = (wifi_pk != '0);
            end
         end
         CLS_IP: begin
            rsp_in.key_type     = {8'd0, op_ff.read_index};
            rsp_in.packet_total = proto_pk;
            rsp_in.byte_total   = proto_by;
            rsp_in.entry_used   = (proto_pk != '0);
         end
         CLS_TCP: begin
            if (r_in_range) begin
               rsp_in.key_type     = range_port(cfg.tcp_first, cfg.tcp_second,
                                                op_ff.read_index, 1'b0);
               rsp_in.key_subtype  = range_port(cfg.tcp_first, cfg.tcp_second,
                                                op_ff.read_index, 1'b1);
               rsp_in.packet_total = tpk_ff[r_idx];
               rsp_in.byte_total   = tby_ff[r_idx];
               rsp_in.entry_used   = (tpk_ff[r_idx] != '0);
            end
         end
         CLS_UDP: begin
            if (r_in_range) begin
               rsp_in.key_type     = range_port(cfg.udp_first, cfg.udp_second,
                                                op_ff.read_index, 1'b0);
               rsp_in.key_subtype  = range_port(cfg.udp_first, cfg.udp_second,
                                                op_ff.read_index, 1'b1);
               rsp_in.packet_total = upk_ff[r_idx];
               rsp_in.byte_total   = uby_ff[r_idx];
               rsp_in.entry_used   = (upk_ff[r_idx] != '0);
            end
         end
         default: begin
            rsp_in.record_class = op_ff.read_class;
         end
      endcase
   end

   assign pop = (state_ff == S_IDLE) && !qstat.empty;

   // Sequencer, counter registers and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         evalid_ff    <= '0;
         wvalid_ff    <= '0;
         pvalid_ff    <= '0;
         for (int i = 0; i < ETHER_SLOTS; i++) begin
            epk_ff[i] <= '0;
            eby_ff[i] <= '0;
         end
         for (int r = 0; r < PORT_RANGES; r++) begin
            tpk_ff[r] <= '0;
            tby_ff[r] <= '0;
            upk_ff[r] <= '0;
            uby_ff[r] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_IDLE;
               if (wifi_we) begin
                  wvalid_ff[wifi_addr] <= 1'b1;
               end
               if (proto_we) begin
                  pvalid_ff[proto_addr] <= 1'b1;
               end
               if (is_read) begin
                  rsp_valid_ff <= 1'b1;
                  if (op_ff.read_class == CLS_ETHER && e_in_range) begin
                     evalid_ff[e_idx] <= 1'b0;
                     epk_ff[e_idx]    <= '0;
                     eby_ff[e_idx]    <= '0;
                  end
                  if (op_ff.read_class == CLS_TCP && r_in_range) begin
                     tpk_ff[r_idx] <= '0;
                     tby_ff[r_idx] <= '0;
                  end
                  if (op_ff.read_class == CLS_UDP && r_in_range) begin
                     upk_ff[r_idx] <= '0;
                     uby_ff[r_idx] <= '0;
                  end
               end else begin
                  if (op_ff.act[CLS_ETHER]) begin
                     if (hit_any) begin
                        epk_ff[e_idx] <= e_pk + 64'd1;
                        eby_ff[e_idx] <= e_by + 64'(op_ff.frame_length);
                     end else if (free_any) begin
                        evalid_ff[e_idx] <= 1'b1;
                        epk_ff[e_idx]    <= 64'd1;
                        eby_ff[e_idx]    <= 64'(op_ff.frame_length);
                     end else begin
                        overflow_ff <= 1'b1;
                     end
                  end
                  for (int r = 0; r < PORT_RANGES; r++) begin
                     if (op_ff.act[CLS_TCP] && op_ff.tcp_hit[r]) begin
                        tpk_ff[r] <= tpk_ff[r] + 64'd1;
                        tby_ff[r] <= tby_ff[r] + 64'(op_ff.l4_length);
                     end
                     if (op_ff.act[CLS_UDP] && op_ff.udp_hit[r]) begin
                        upk_ff[r] <= upk_ff[r] + 64'd1;
                        uby_ff[r] <= uby_ff[r] + 64'(op_ff.l4_length);
                     end
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      // Payload registers.
      if (pop) begin
         op_ff <= head_op;
      end
      if (is_exec && is_read && op_ff.read_class == CLS_ETHER && !e_in_range) begin
         rsp_ff <= rsp_in;
      end else if (is_exec && !is_read && op_ff.act[CLS_ETHER] && !hit_any && free_any) begin
         ekey_ff[e_idx] <= op_ff.ether_type;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign overflow   = overflow_ff;

endmodule

// ===== rtl/traffic_class_counters_core.sv =====
// Top level of the traffic class counter core: configuration registers,
// front end, work queue and back end. Depends on tcc_pkg and all rtl modules.
//
// Usage: a request is taken when start is high and busy is low. A count
// request adds one packet and its bytes to every enabled class whose header
// is present (TCP and UDP only with the IP header, and only to the port
// ranges that match); a read request of an existing class returns one entry
// on rsp_data, marked by a single-cycle rsp_strobe that cannot be held off,
// and clears that entry. The back end handles each request in S_IDLE, with
// the table RAM read, and then in S_EXEC, with the update and write-back,
// and takes no new request until the last one is written back. A read
// result is registered at the end of S_EXEC, after the request leaves the
// two-entry queue. Busy is high only while that queue is full. Counter tables
// start at zero right after reset with no clearing pass. Configuration is
// written through the csr channel, which is always ready, and must only
// change while no request is in flight.
module traffic_class_counters_core #(
   parameter int ETHER_SLOTS = tcc_pkg::ETHER_SLOTS_DEF,
   parameter int PORT_RANGES = tcc_pkg::PORT_RANGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tcc_pkg::tcc_req_type req_data,
   output logic                 rsp_strobe,
   output tcc_pkg::tcc_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_wdata
);
   import tcc_pkg::*;

   tcc_cfg_type   cfg_ff;
   tcc_op_type    front_op, head_op;
   tcc_qstat_type qstat;
   logic          keep, push, pop, overflow;

   assign csr_ready = 1'b1;

   // Configuration register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable: 5'h1F, default: '0};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:     cfg_ff.enable     <= csr_wdata[4:0];
            CSR_TCP_COUNT:  cfg_ff.tcp_count  <= csr_wdata[2:0];
            CSR_UDP_COUNT:  cfg_ff.udp_count  <= csr_wdata[2:0];
            CSR_TCP_FIRST:  cfg_ff.tcp_first  <= csr_wdata;
            CSR_TCP_SECOND: cfg_ff.tcp_second <= csr_wdata;
            CSR_UDP_FIRST:  cfg_ff.udp_first  <= csr_wdata;
            CSR_UDP_SECOND: cfg_ff.udp_second <= csr_wdata;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   tcc_front #(.PORT_RANGES(PORT_RANGES)) u_front (
      .req(req_data), .cfg(cfg_ff), .op(front_op), .keep(keep)
   );

   // A transfer on the request side enters the queue unless it is dropped.
   assign busy = qstat.full;
   assign push = start && !busy && keep;

   tcc_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_op(front_op),
      .pop(pop), .head_op(head_op), .stat(qstat)
   );

   tcc_back #(.ETHER_SLOTS(ETHER_SLOTS), .PORT_RANGES(PORT_RANGES)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .head_op(head_op),
      .qstat(qstat), .pop(pop), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .overflow(overflow)
   );

`include "traffic_class_counters_core_assert.svh"

   // Results never come back to back.
   `TCC_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_strobe, !rsp_strobe, "back-to-back results")
   // Only existing classes are reported.
   `TCC_ASSERT_SAME(a_rsp_class, clock, reset, rsp_strobe, rsp_data.record_class <= CLS_UDP, "bad class")
   // The overflow flag never falls outside reset.
   `TCC_ASSERT_NEXT(a_ovf_sticky, clock, reset, overflow, overflow, "overflow flag cleared")
   // Nothing leaves an empty queue.
   `TCC_ASSERT_SAME(a_pop_empty, clock, reset, pop, !qstat.empty, "pop from empty queue")

endmodule

// ===== bench/traffic_class_counters_core_test.sv =====
// Self-checking bench for the traffic class counter core: random and directed
// count and read requests, with expected records tracked by a scoreboard.
// Depends on tcc_pkg and the traffic_class_counters_core RTL.
`timescale 1ns / 100ps

import tcc_pkg::*;

// Tracks the counter tables as the core should hold them and queues the
// records that read requests should return.
class counter_tracker;
   logic [4:0]  enable;
   logic [2:0]  range_count [2];
   logic [63:0] range_word [2][2];
   logic [15:0] eth_key [16];
   bit          eth_valid [16];
   logic [63:0] eth_pkts [16];
   logic [63:0] eth_bytes [16];
   logic [63:0] wifi_pkts [64];
   logic [63:0] wifi_bytes [64];
   logic [63:0] proto_pkts [256];
   logic [63:0] proto_bytes [256];
   logic [63:0] range_pkts [2][4];
   logic [63:0] range_bytes [2][4];
   bit          overflow;
   tcc_rsp_type pending_records [$];
   int          fails;

   function new();
      enable = 5'd31;
      overflow = 0;
      fails = 0;
      for (int c = 0; c < 2; c++) begin
         range_count[c] = '0;
         range_word[c][0] = '0;
         range_word[c][1] = '0;
         for (int r = 0; r < 4; r++) begin
            range_pkts[c][r] = '0;
            range_bytes[c][r] = '0;
         end
      end
      for (int i = 0; i < 16; i++) begin
         eth_key[i] = '0;
         eth_valid[i] = 0;
         eth_pkts[i] = '0;
         eth_bytes[i] = '0;
      end
      for (int i = 0; i < 64; i++) begin
         wifi_pkts[i] = '0;
         wifi_bytes[i] = '0;
      end
      for (int i = 0; i < 256; i++) begin
         proto_pkts[i] = '0;
         proto_bytes[i] = '0;
      end
   endfunction

   function void set_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
         CSR_ENABLE:     enable = value[4:0];
         CSR_TCP_COUNT:  range_count[0] = value[2:0];
         CSR_UDP_COUNT:  range_count[1] = value[2:0];
         CSR_TCP_FIRST:  range_word[0][0] = value;
         CSR_TCP_SECOND: range_word[0][1] = value;
         CSR_UDP_FIRST:  range_word[1][0] = value;
         CSR_UDP_SECOND: range_word[1][1] = value;
         default: ;
      endcase
   endfunction

   function logic [15:0] port_of(int c, int r, bit hi);
      logic [63:0] word;
      if (r > 3) return 16'd0;
      word = range_word[c][r / 2];
      return word[(r % 2) * 32 + (hi ? 16 : 0) +: 16];
   endfunction

   function void add_ranges(int c, logic [15:0] sp, logic [15:0] dp, logic [15:0] len);
      int n;
      logic [15:0] lo, hi;
      n = (range_count[c] > 4) ? 4 : int'(range_count[c]);
      for (int r = 0; r < n; r++) begin
         lo = port_of(c, r, 0);
         hi = port_of(c, r, 1);
         if ((sp >= lo && sp <= hi) || (dp >= lo && dp <= hi)) begin
            range_pkts[c][r] += 1;
            range_bytes[c][r] += len;
         end
      end
   endfunction

   // A hit adds to its slot, a miss takes the lowest free slot, and a miss
   // on a full table only raises the sticky overflow flag.
   function void add_ether(logic [15:0] et, logic [15:0] len);
      for (int i = 0; i < 16; i++) begin
         if (eth_valid[i] && eth_key[i] == et) begin
            eth_pkts[i] += 1;
            eth_bytes[i] += len;
            return;
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (!eth_valid[i]) begin
            eth_valid[i] = 1;
            eth_key[i] = et;
            eth_pkts[i] = 1;
            eth_bytes[i] = len;
            return;
         end
      end
      overflow = 1;
   endfunction

   // Notes one accepted request.
   function void log_request(tcc_req_type q);
      logic [4:0]  act;
      logic [15:0] hdr;
      logic [15:0] l4;
      tcc_rsp_type r;
      int          idx;
      int          c;
      if (q.cmd == CMD_COUNT) begin
         act = q.present_mask & enable;
         hdr = {10'd0, q.ip_header_words, 2'b00};
         l4 = (q.ip_total_length >= hdr) ? q.ip_total_length - hdr : 16'd0;
         if (act[CLS_ETHER]) add_ether(q.ether_type, q.frame_length);
         if (act[CLS_WIFI]) begin
            wifi_pkts[q.wifi_kind] += 1;
            wifi_bytes[q.wifi_kind] += q.frame_length;
         end
         if (act[CLS_IP]) begin
            proto_pkts[q.ip_protocol] += 1;
            proto_bytes[q.ip_protocol] += q.ip_total_length;
         end
         if (act[CLS_TCP] && q.present_mask[CLS_IP])
            add_ranges(0, q.source_port, q.dest_port, l4);
         if (act[CLS_UDP] && q.present_mask[CLS_IP])
            add_ranges(1, q.source_port, q.dest_port, l4);
         return;
      end
      // Read and clear; an index beyond the class returns an empty record.
      if (q.read_class > CLS_UDP) return;
      r = '0;
      r.record_class = q.read_class;
      idx = int'(q.read_index);
      case (q.read_class)
         CLS_ETHER: begin
            if (idx < 16) begin
               if (eth_valid[idx]) begin
                  r.key_type = eth_key[idx];
                  r.entry_used = 1;
               end
               r.packet_total = eth_pkts[idx];
               r.byte_total = eth_bytes[idx];
               eth_valid[idx] = 0;
               eth_pkts[idx] = '0;
               eth_bytes[idx] = '0;
            end
         end
         CLS_WIFI: begin
            if (idx < 64) begin
               r.key_type = 16'(idx % 4);
               r.key_subtype = 16'(idx / 4);
               r.packet_total = wifi_pkts[idx];
               r.byte_total = wifi_bytes[idx];
               r.entry_used = (wifi_pkts[idx] != 0);
               wifi_pkts[idx] = '0;
               wifi_bytes[idx] = '0;
            end
         end
         CLS_IP: begin
            r.key_type = 16'(idx);
            r.packet_total = proto_pkts[idx];
            r.byte_total = proto_bytes[idx];
            r.entry_used = (proto_pkts[idx] != 0);
            proto_pkts[idx] = '0;
            proto_bytes[idx] = '0;
         end
         default: begin
            c = (q.read_class == CLS_TCP) ? 0 : 1;
            if (idx < 4) begin
               r.key_type = port_of(c, idx, 0);
               r.key_subtype = port_of(c, idx, 1);
               r.packet_total = range_pkts[c][idx];
               r.byte_total = range_bytes[c][idx];
               r.entry_used = (range_pkts[c][idx] != 0);
               range_pkts[c][idx] = '0;
               range_bytes[c][idx] = '0;
            end
         end
      endcase
      r.ether_overflow = overflow;
      pending_records = {pending_records, r};
   endfunction

   // Compares one returned record with the oldest expected one.
   function void match_record(tcc_rsp_type a);
      tcc_rsp_type e;
      if (pending_records.size() == 0) begin
         $error("unexpected record: class %0d", a.record_class);
         fails++;
         return;
      end
      e = pending_records.pop_front();
      if (a.record_class !== e.record_class) begin
         $error("record_class: expected %0d, got %0d", e.record_class, a.record_class);
         fails++;
      end
      if (a.key_type !== e.key_type) begin
         $error("key_type: expected %0h, got %0h", e.key_type, a.key_type);
         fails++;
      end
      if (a.key_subtype !== e.key_subtype) begin
         $error("key_subtype: expected %0h, got %0h", e.key_subtype, a.key_subtype);
         fails++;
      end
      if (a.packet_total !== e.packet_total) begin
         $error("packet_total: expected %0d, got %0d", e.packet_total, a.packet_total);
         fails++;
      end
      if (a.byte_total !== e.byte_total) begin
         $error("byte_total: expected %0d, got %0d", e.byte_total, a.byte_total);
         fails++;
      end
      if (a.entry_used !== e.entry_used) begin
         $error("entry_used: expected %0b, got %0b", e.entry_used, a.entry_used);
         fails++;
      end
      if (a.ether_overflow !== e.ether_overflow) begin
         $error("ether_overflow: expected %0b, got %0b", e.ether_overflow,
                a.ether_overflow);
         fails++;
      end
   endfunction
endclass

module traffic_class_counters_core_test;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int REQ_W = $bits(tcc_req_type);

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   tcc_req_type req_data;
   logic        rsp_strobe;
   tcc_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   counter_tracker tracker;
   int          stall_cycles;
   bit          burst_mode;

   traffic_class_counters_core u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe transfers at the rising edge and watch for a stalled run.
   always @(posedge clock) begin
      if (!reset) begin
         stall_cycles++;
         if (start && !busy) begin
            tracker.log_request(req_data);
            stall_cycles = 0;
         end
         if (rsp_strobe) begin
            tracker.match_record(rsp_data);
            stall_cycles = 0;
         end
         if (csr_valid && csr_ready) stall_cycles = 0;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Hand one request to the core after a random gap, or with none in burst mode.
   task automatic send(tcc_req_type q);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_data = q;
      do @(posedge clock); while (busy);
   endtask

   // Stop sending and wait for every expected record plus the pipeline tail.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (tracker.pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_range_pair();
      logic [15:0] lo, hi;
      case ($urandom_range(0, 3))
         0: begin
            lo = 16'($urandom_range(0, 4000));
            hi = 16'(lo + $urandom_range(0, 4000));
         end
         1: begin
            hi = 16'($urandom_range(0, 4000));
            lo = 16'(hi + $urandom_range(1, 500));
         end
         2: begin
            lo = 16'h0000;
            hi = 16'hffff;
         end
         default: begin
            lo = 16'($urandom);
            hi = 16'($urandom);
         end
      endcase
      return {hi, lo};
   endfunction

   function automatic tcc_req_type random_request();
      tcc_req_type q;
      q = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      q.cmd = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_COUNT;
      if (q.cmd == CMD_COUNT) begin
         // A small ethertype pool keeps the table filling and hitting.
         if ($urandom_range(0, 9) < 8) q.ether_type = 16'(16'h0800 + $urandom_range(0, 19));
         if ($urandom_range(0, 9) < 6) q.source_port = 16'($urandom_range(0, 8000));
         if ($urandom_range(0, 9) < 6) q.dest_port = 16'($urandom_range(0, 8000));
         if ($urandom_range(0, 4) == 0) q.ip_total_length = 16'($urandom_range(0, 80));
         if ($urandom_range(0, 3) != 0) q.present_mask[CLS_IP] = 1'b1;
      end else begin
         q.read_class = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
         if ($urandom_range(0, 4) != 0) begin
            case (q.read_class)
               CLS_ETHER: q.read_index = 8'($urandom_range(0, 15));
               CLS_WIFI:  q.read_index = 8'($urandom_range(0, 63));
               CLS_TCP, CLS_UDP: q.read_index = 8'($urandom_range(0, 3));
               default: ;
            endcase
         end
      end
      return q;
   endfunction

   function automatic tcc_req_type count_request(logic [4:0] present, logic [15:0] et);
      tcc_req_type q;
      q = '0;
      q.cmd = CMD_COUNT;
      q.present_mask = present;
      q.ether_type = et;
      q.frame_length = 16'd100;
      q.ip_total_length = 16'd60;
      q.ip_header_words = 4'd5;
      q.source_port = 16'd80;
      return q;
   endfunction

   function automatic tcc_req_type read_request(logic [2:0] cls, logic [7:0] idx);
      tcc_req_type q;
      q = '0;
      q.cmd = CMD_READ;
      q.read_class = cls;
      q.read_index = idx;
      return q;
   endfunction

   initial begin
      tcc_req_type q;
      logic [63:0] words [4];
      tracker = new();
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      stall_cycles = 0;
      burst_mode = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: all-ones and all-zero packets, short IP length,
      // layer 4 without IP, table overflow, and reads in and beyond range.
      write_reg(CSR_TCP_COUNT, 64'd4);
      write_reg(CSR_UDP_COUNT, 64'd7);
      write_reg(CSR_TCP_FIRST, {16'hffff, 16'h0000, 16'd90, 16'd70});
      write_reg(CSR_TCP_SECOND, {16'hffff, 16'hffff, 16'd10, 16'd20});
      write_reg(CSR_UDP_FIRST, {16'd100, 16'd0, 16'hffff, 16'h0000});
      write_reg(CSR_UDP_SECOND, {16'd80, 16'd80, 16'd5000, 16'd1000});
      q = '1;
      q.cmd = CMD_COUNT;
      send(q);
      q = '0;
      send(q);
      q = count_request(5'b11111, 16'h0800);
      q.ip_total_length = 16'd10;
      q.ip_header_words = 4'd15;
      send(q);
      send(count_request(5'b11000, 16'h0800));
      for (int i = 0; i < 17; i++) send(count_request(5'b00001, 16'h9000 + 16'(i)));
      send(read_request(CLS_ETHER, 8'd0));
      send(read_request(CLS_ETHER, 8'd200));
      send(read_request(CLS_WIFI, 8'd63));
      send(read_request(CLS_WIFI, 8'd100));
      send(read_request(CLS_IP, 8'd255));
      send(read_request(CLS_TCP, 8'd3));
      send(read_request(CLS_TCP, 8'd9));
      send(read_request(CLS_UDP, 8'd0));
      send(read_request(3'd5, 8'd0));
      send(read_request(3'd7, 8'd1));
      drain();

      // Random phases, each under its own register settings.
      for (int ph = 0; ph < PHASES; ph++) begin
         for (int w = 0; w < 4; w++) begin
            words[w] = {random_range_pair(), random_range_pair()};
            if (ph == 3) words[w] = '0;
            if (ph == 4) words[w] = '1;
         end
         write_reg(CSR_ENABLE, (ph == 1) ? 64'd0 : (ph == 2) ? 64'd31
                                         : 64'($urandom_range(0, 31)));
         write_reg(CSR_TCP_COUNT, (ph == 2) ? 64'd7 : (ph == 3) ? 64'd0
                                            : 64'($urandom_range(0, 7)));
         write_reg(CSR_UDP_COUNT, (ph == 2) ? 64'd7 : (ph == 3) ? 64'd0
                                            : 64'($urandom_range(0, 7)));
         write_reg(CSR_TCP_FIRST, words[0]);
         write_reg(CSR_TCP_SECOND, words[1]);
         write_reg(CSR_UDP_FIRST, words[2]);
         write_reg(CSR_UDP_SECOND, words[3]);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Switch now and then between back-to-back and gapped traffic.
            if (i % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            send(random_request());
         end
         drain();
      end

      if (tracker.fails == 0 && tracker.pending_records.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tcc_pkg.sv
rtl/tcc_ram.sv
rtl/tcc_queue.sv
rtl/tcc_front.sv
rtl/tcc_back.sv
rtl/traffic_class_counters_core.sv
bench/traffic_class_counters_core_test.sv
